// ----- src/ppp_pkg.sv -----
package ppp_pkg;

  // Field and datapath widths
  localparam int PT_W    = 12;  // model coordinate
  localparam int TRIG_W  = 18;  // Q16 sine and cosine
  localparam int EYE_W   = 13;  // eye distance
  localparam int SCALE_W = 10;  // scale numerator
  localparam int SC_W    = 13;  // scaled coordinate, |v| <= 2095
  localparam int ROT_W   = 16;  // rotated coordinate, |v| <= 20953
  localparam int MA_W    = 16;  // multiplier operand A (signed)
  localparam int MB_W    = 18;  // multiplier operand B (signed)
  localparam int PROD_W  = 32;  // product and accumulator
  localparam int ROT_SH  = 16;  // Q16 fraction bits
  localparam int DIV_W   = 28;  // dividend magnitude, below 2^28
  localparam int DEN_W   = 16;  // divisor
  localparam int DCNT_W  = $clog2(DIV_W);
  localparam int SCR_W   = 16;  // screen coordinate
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [DEN_W-1:0] SCALE_DIVISOR = DEN_W'(1000);

  // Divide by 1000 as a reciprocal multiply: exact for magnitudes below 2^21
  localparam int SCL_N_W = 21;  // magnitude of coordinate times scale
  localparam int RCP_SH  = 31;  // reciprocal fraction bits
  localparam int RCP_W   = 22;  // reciprocal width
  localparam logic [RCP_W-1:0] SCALE_RECIP =
    RCP_W'(((longint'(1) << RCP_SH) + longint'(SCALE_DIVISOR) - 1) / longint'(SCALE_DIVISOR));

  // Register reset values
  localparam logic signed [TRIG_W-1:0] SIN_RESET   = TRIG_W'(0);
  localparam logic signed [TRIG_W-1:0] COS_RESET   = TRIG_W'(65536);
  localparam logic [EYE_W-1:0]         EYE_RESET   = EYE_W'(2600);
  localparam logic [SCALE_W-1:0]       SCALE_RESET = SCALE_W'(1000);

  typedef enum logic [2:0] {
    REG_SIN_YAW      = 3'd0,
    REG_COS_YAW      = 3'd1,
    REG_SIN_PITCH    = 3'd2,
    REG_COS_PITCH    = 3'd3,
    REG_EYE_DISTANCE = 3'd4,
    REG_MODEL_SCALE  = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCL_MUL,
    ST_SCL_DIV,
    ST_SCL_WAIT,
    ST_ROT_M1,
    ST_ROT_M2,
    ST_ROT_ADD,
    ST_PRJ_MUL,
    ST_PRJ_DIV,
    ST_PRJ_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_yaw;
    logic signed [TRIG_W-1:0] cos_yaw;
    logic signed [TRIG_W-1:0] sin_pitch;
    logic signed [TRIG_W-1:0] cos_pitch;
    logic [EYE_W-1:0]         eye_distance;
    logic [SCALE_W-1:0]       model_scale;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- src/ppp_cfg.sv -----
module ppp_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppp_pkg::ADDR_W-1:0]   paddr,
  input  logic [ppp_pkg::DATA_W-1:0]   pwdata,
  output logic [ppp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output ppp_pkg::cfg_t                cfg
);

  ppp_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = ppp_pkg::reg_idx_t'(paddr[ppp_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sin_yaw      <= ppp_pkg::SIN_RESET;
      cfg.cos_yaw      <= ppp_pkg::COS_RESET;
      cfg.sin_pitch    <= ppp_pkg::SIN_RESET;
      cfg.cos_pitch    <= ppp_pkg::COS_RESET;
      cfg.eye_distance <= ppp_pkg::EYE_RESET;
      cfg.model_scale  <= ppp_pkg::SCALE_RESET;
    end else if (wr_en) begin
      unique case (idx)
        ppp_pkg::REG_SIN_YAW:      cfg.sin_yaw      <= pwdata[ppp_pkg::TRIG_W-1:0];
        ppp_pkg::REG_COS_YAW:      cfg.cos_yaw      <= pwdata[ppp_pkg::TRIG_W-1:0];
        ppp_pkg::REG_SIN_PITCH:    cfg.sin_pitch    <= pwdata[ppp_pkg::TRIG_W-1:0];
        ppp_pkg::REG_COS_PITCH:    cfg.cos_pitch    <= pwdata[ppp_pkg::TRIG_W-1:0];
        ppp_pkg::REG_EYE_DISTANCE: cfg.eye_distance <= pwdata[ppp_pkg::EYE_W-1:0];
        ppp_pkg::REG_MODEL_SCALE:  cfg.model_scale  <= pwdata[ppp_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, sign-extending the angle registers
  always_comb begin
    unique case (idx)
      ppp_pkg::REG_SIN_YAW:
        prdata = {{(ppp_pkg::DATA_W-ppp_pkg::TRIG_W){cfg.sin_yaw[ppp_pkg::TRIG_W-1]}},
                  cfg.sin_yaw};
      ppp_pkg::REG_COS_YAW:
        prdata = {{(ppp_pkg::DATA_W-ppp_pkg::TRIG_W){cfg.cos_yaw[ppp_pkg::TRIG_W-1]}},
                  cfg.cos_yaw};
      ppp_pkg::REG_SIN_PITCH:
        prdata = {{(ppp_pkg::DATA_W-ppp_pkg::TRIG_W){cfg.sin_pitch[ppp_pkg::TRIG_W-1]}},
                  cfg.sin_pitch};
      ppp_pkg::REG_COS_PITCH:
        prdata = {{(ppp_pkg::DATA_W-ppp_pkg::TRIG_W){cfg.cos_pitch[ppp_pkg::TRIG_W-1]}},
                  cfg.cos_pitch};
      ppp_pkg::REG_EYE_DISTANCE:
        prdata = {{(ppp_pkg::DATA_W-ppp_pkg::EYE_W){1'b0}}, cfg.eye_distance};
      ppp_pkg::REG_MODEL_SCALE:
        prdata = {{(ppp_pkg::DATA_W-ppp_pkg::SCALE_W){1'b0}}, cfg.model_scale};
      default:
        prdata = '0;
    endcase
  end

endmodule

// ----- src/ppp_div.sv -----
module ppp_div (
  input  logic              clk,
  input  logic              rst,
  input  ppp_pkg::div_req_t req,
  output ppp_pkg::div_rsp_t rsp
);

  logic                         busy;
  logic                         done;
  logic [ppp_pkg::DCNT_W-1:0]   count;
  logic [ppp_pkg::DEN_W-1:0]    divisor;
  logic [ppp_pkg::DEN_W-1:0]    rem;
  logic [ppp_pkg::DIV_W-1:0]    quo;
  logic [ppp_pkg::DEN_W:0]      trial;

  // Shift in next dividend bit and try the subtract
  assign trial = {rem, quo[ppp_pkg::DIV_W-1]} - {1'b0, divisor};

  // Control: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= ppp_pkg::DCNT_W'(ppp_pkg::DIV_W - 1);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring division datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      rem     <= '0;
      quo     <= req.dividend;
    end else if (busy) begin
      if (!trial[ppp_pkg::DEN_W]) begin
        rem <= trial[ppp_pkg::DEN_W-1:0];
        quo <= {quo[ppp_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem <= {rem[ppp_pkg::DEN_W-2:0], quo[ppp_pkg::DIV_W-1]};
        quo <= {quo[ppp_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ----- src/perspective_polyline_projector.sv -----
// One request in flight at a time.
// Time is set by two passes through the shared restoring divider (the perspective divides,
// each with operand setup), three scale divides by 1000 done as reciprocal multiplies,
// and four rotation sums, each two products on the shared multiplier and an add.
// Reset: synchronous, clears control, registers to defaults, previous point to (0,0).
module perspective_polyline_projector (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ppp_pkg::ADDR_W-1:0]         paddr,
  input  logic [ppp_pkg::DATA_W-1:0]         pwdata,
  output logic [ppp_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               start_of_chain,
  input  logic signed [ppp_pkg::PT_W-1:0]    point_x,
  input  logic signed [ppp_pkg::PT_W-1:0]    point_y,
  input  logic signed [ppp_pkg::PT_W-1:0]    point_z,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ppp_pkg::SCR_W-1:0]   screen_x,
  output logic signed [ppp_pkg::SCR_W-1:0]   screen_y,
  output logic                               draw_segment,
  output logic signed [ppp_pkg::SCR_W-1:0]   from_x,
  output logic signed [ppp_pkg::SCR_W-1:0]   from_y
);

  ppp_pkg::cfg_t     cfg;
  ppp_pkg::div_req_t div_req;
  ppp_pkg::div_rsp_t div_rsp;
  ppp_pkg::state_t   state, state_next;
  logic [1:0]        idx, idx_next;

  logic                               in_accept;
  logic                               out_load;
  logic                               chain_start;
  logic signed [ppp_pkg::PT_W-1:0]    pt_x, pt_y, pt_z;
  logic signed [ppp_pkg::PT_W-1:0]    pt_sel;
  logic signed [ppp_pkg::SC_W-1:0]    sc_x, sc_y, sc_z;
  logic signed [ppp_pkg::ROT_W-1:0]   x1, z1, y2, z2;
  logic signed [ppp_pkg::SCR_W-1:0]   sx, sy;
  logic signed [ppp_pkg::SCR_W-1:0]   last_x, last_y;
  logic [ppp_pkg::DEN_W-1:0]          den;
  logic signed [ppp_pkg::DEN_W:0]     den_sum;
  logic                               div_neg;

  logic signed [ppp_pkg::MA_W-1:0]          mul_a;
  logic signed [ppp_pkg::MB_W-1:0]          mul_b;
  logic signed [ppp_pkg::MA_W+ppp_pkg::MB_W-1:0] mul_full;
  logic signed [ppp_pkg::PROD_W-1:0]        prod, acc, rot_sum;
  logic [ppp_pkg::PROD_W-1:0]               prod_abs;
  logic [ppp_pkg::DIV_W-1:0]                q_sgn;
  logic [ppp_pkg::SCL_N_W+ppp_pkg::RCP_W-1:0] rcp_full;
  logic [ppp_pkg::SC_W-1:0]                 scl_q, scl_sgn;

  ppp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ppp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_stall  = (state != ppp_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == ppp_pkg::ST_FINISH) && (!out_valid || !out_stall);

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppp_pkg::ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // Next state and divider control
  always_comb begin
    state_next = state;
    idx_next   = idx;
    div_req.start    = 1'b0;
    div_req.dividend = prod_abs[ppp_pkg::DIV_W-1:0];
    div_req.divisor  = den;
    unique case (state)
      ppp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = ppp_pkg::ST_SCL_MUL;
          idx_next   = '0;
        end
      end
      ppp_pkg::ST_SCL_MUL: state_next = ppp_pkg::ST_SCL_DIV;
      ppp_pkg::ST_SCL_DIV: state_next = ppp_pkg::ST_SCL_WAIT;
      ppp_pkg::ST_SCL_WAIT: begin
        if (idx == 2'd2) begin
          state_next = ppp_pkg::ST_ROT_M1;
          idx_next   = '0;
        end else begin
          state_next = ppp_pkg::ST_SCL_MUL;
          idx_next   = idx + 1'b1;
        end
      end
      ppp_pkg::ST_ROT_M1: state_next = ppp_pkg::ST_ROT_M2;
      ppp_pkg::ST_ROT_M2: state_next = ppp_pkg::ST_ROT_ADD;
      ppp_pkg::ST_ROT_ADD: begin
        if (idx == 2'd3) begin
          state_next = ppp_pkg::ST_PRJ_MUL;
          idx_next   = '0;
        end else begin
          state_next = ppp_pkg::ST_ROT_M1;
          idx_next   = idx + 1'b1;
        end
      end
      ppp_pkg::ST_PRJ_MUL: state_next = ppp_pkg::ST_PRJ_DIV;
      ppp_pkg::ST_PRJ_DIV: begin
        div_req.start = 1'b1;
        state_next    = ppp_pkg::ST_PRJ_WAIT;
      end
      ppp_pkg::ST_PRJ_WAIT: begin
        if (div_rsp.done) begin
          if (idx == 2'd1) begin
            state_next = ppp_pkg::ST_FINISH;
          end else begin
            state_next = ppp_pkg::ST_PRJ_MUL;
            idx_next   = idx + 1'b1;
          end
        end
      end
      ppp_pkg::ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = ppp_pkg::ST_IDLE;
        end
      end
      default: state_next = ppp_pkg::ST_IDLE;
    endcase
  end

  // Pick the input coordinate being scaled
  always_comb begin
    case (idx)
      2'd0:    pt_sel = pt_x;
      2'd1:    pt_sel = pt_y;
      default: pt_sel = pt_z;
    endcase
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ppp_pkg::ST_SCL_MUL: begin
        mul_a = ppp_pkg::MA_W'(pt_sel);
        mul_b = {{(ppp_pkg::MB_W-ppp_pkg::SCALE_W){1'b0}}, cfg.model_scale};
      end
      ppp_pkg::ST_ROT_M1: begin
        case (idx)
          2'd0:    begin mul_a = ppp_pkg::MA_W'(sc_x); mul_b = cfg.cos_yaw;   end
          2'd1:    begin mul_a = ppp_pkg::MA_W'(sc_x); mul_b = cfg.sin_yaw;   end
          2'd2:    begin mul_a = ppp_pkg::MA_W'(sc_y); mul_b = cfg.cos_pitch; end
          default: begin mul_a = ppp_pkg::MA_W'(sc_y); mul_b = cfg.sin_pitch; end
        endcase
      end
      ppp_pkg::ST_ROT_M2: begin
        case (idx)
          2'd0:    begin mul_a = ppp_pkg::MA_W'(sc_z); mul_b = cfg.sin_yaw;   end
          2'd1:    begin mul_a = ppp_pkg::MA_W'(sc_z); mul_b = cfg.cos_yaw;   end
          2'd2:    begin mul_a = z1;                   mul_b = cfg.sin_pitch; end
          default: begin mul_a = z1;                   mul_b = cfg.cos_pitch; end
        endcase
      end
      ppp_pkg::ST_PRJ_MUL: begin
        mul_a = (idx == 2'd0) ? x1 : y2;
        mul_b = {{(ppp_pkg::MB_W-ppp_pkg::EYE_W){1'b0}}, cfg.eye_distance};
      end
      default: ;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // Rotation combine: x1 and y2 subtract, z1 and z2 add
  assign rot_sum  = idx[0] ? (acc + prod) : (acc - prod);
  assign prod_abs = prod[ppp_pkg::PROD_W-1] ? ppp_pkg::PROD_W'(-prod)
                                            : ppp_pkg::PROD_W'(prod);
  assign q_sgn    = div_neg ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;

  // Scale divide by 1000: multiply the magnitude by the reciprocal, restore the sign
  assign rcp_full = prod_abs[ppp_pkg::SCL_N_W-1:0] * ppp_pkg::SCALE_RECIP;
  assign scl_sgn  = div_neg ? (~scl_q + 1'b1) : scl_q;

  // Eye distance plus depth, floored at one
  assign den_sum = $signed({{(ppp_pkg::DEN_W+1-ppp_pkg::EYE_W){1'b0}}, cfg.eye_distance})
                 + (ppp_pkg::DEN_W+1)'(z2);

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ppp_pkg::ST_IDLE: begin
        if (in_accept) begin
          chain_start <= start_of_chain;
          pt_x        <= point_x;
          pt_y        <= point_y;
          pt_z        <= point_z;
        end
      end
      ppp_pkg::ST_SCL_MUL: begin
        prod <= mul_full[ppp_pkg::PROD_W-1:0];
      end
      ppp_pkg::ST_SCL_DIV: begin
        div_neg <= prod[ppp_pkg::PROD_W-1];
        scl_q   <= {1'b0, rcp_full[ppp_pkg::RCP_SH +: ppp_pkg::SC_W-1]};
      end
      ppp_pkg::ST_SCL_WAIT: begin
        case (idx)
          2'd0:    sc_x <= scl_sgn;
          2'd1:    sc_y <= scl_sgn;
          default: sc_z <= scl_sgn;
        endcase
      end
      ppp_pkg::ST_ROT_M1: begin
        prod <= mul_full[ppp_pkg::PROD_W-1:0];
      end
      ppp_pkg::ST_ROT_M2: begin
        acc  <= prod;
        prod <= mul_full[ppp_pkg::PROD_W-1:0];
      end
      ppp_pkg::ST_ROT_ADD: begin
        case (idx)
          2'd0:    x1 <= rot_sum[ppp_pkg::PROD_W-1:ppp_pkg::ROT_SH];
          2'd1:    z1 <= rot_sum[ppp_pkg::PROD_W-1:ppp_pkg::ROT_SH];
          2'd2:    y2 <= rot_sum[ppp_pkg::PROD_W-1:ppp_pkg::ROT_SH];
          default: z2 <= rot_sum[ppp_pkg::PROD_W-1:ppp_pkg::ROT_SH];
        endcase
      end
      ppp_pkg::ST_PRJ_MUL: begin
        prod <= mul_full[ppp_pkg::PROD_W-1:0];
        if (den_sum < $signed((ppp_pkg::DEN_W+1)'(1))) begin
          den <= ppp_pkg::DEN_W'(1);
        end else begin
          den <= den_sum[ppp_pkg::DEN_W-1:0];
        end
      end
      ppp_pkg::ST_PRJ_DIV: begin
        div_neg <= prod[ppp_pkg::PROD_W-1];
      end
      ppp_pkg::ST_PRJ_WAIT: begin
        if (div_rsp.done) begin
          if (idx == 2'd0) begin
            sx <= q_sgn[ppp_pkg::SCR_W-1:0];
          end else begin
            sy <= q_sgn[ppp_pkg::SCR_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // Result register and previous point
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      last_x    <= '0;
      last_y    <= '0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      last_x    <= sx;
      last_y    <= sy;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      screen_x     <= sx;
      screen_y     <= sy;
      draw_segment <= !chain_start;
      from_x       <= chain_start ? '0 : last_x;
      from_y       <= chain_start ? '0 : last_y;
    end
  end

endmodule
